// ===== sv/hnd_pkg.sv =====
package hnd_pkg;

  localparam int unsigned POS_W = 11;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned PROD_W = 35;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_RD2,
    ST_RD3,
    ST_RD5,
    ST_CALC,
    ST_FINISH
  } hnd_state_t;

endpackage

// ===== sv/hnd_ram.sv =====
module hnd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/hamming_number_dp_core.sv =====
// Returns the n-th 5-smooth (Hamming) number for a requested one-based position.
// A request arrives on the in_ channel: in_tdata carries the 11-bit position.
// The answer leaves on the out_ channel: out_tdata carries the 32-bit value and
// out_tuser flags a bad request (position zero or above MAX_N), in which case
// the value is zero.
// One request is worked on at a time. For a valid position n the sequence is
// rebuilt in a single-port table memory: each new entry takes three reads
// (for the double, triple and quintuple candidates), followed by picking the
// smallest and writing it back. A bad request skips the table and goes
// straight to the result register. No new request is accepted until the
// result of the current one has been loaded into the result register.
// The result sits in an output register, so a stalled receiver holds it there
// while the block may accept the next request; a finished computation then
// waits until the output register is free.
// Reset (rst_n low, synchronous) returns the block to idle with no result
// pending. The table memory needs no clearing, since every entry is written
// before it is read within a request.
module hamming_number_dp_core #(
  parameter int unsigned MAX_N = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // [10:0] position, [15:11] zero
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [hnd_pkg::VAL_W-1:0]   out_tdata,  // [31:0] value
  output logic                        out_tuser   // [0] bad_request
);
  import hnd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_N);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_N);

  hnd_state_t state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] idx_r, idx_nxt;
  logic [AW-1:0] p2_r, p2_nxt, p3_r, p3_nxt, p5_r, p5_nxt;
  logic [VAL_W-1:0] d2_r, d2_nxt, d3_r, d3_nxt;
  logic [VAL_W-1:0] last_r, last_nxt;
  logic bad_r, bad_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  logic out_bad_r, out_bad_nxt;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;

  logic [PROD_W-1:0] c2, c3, c5, min_val, min23;
  logic [POS_W-1:0] in_pos;

  assign in_pos = in_tdata[POS_W-1:0];

  assign c2 = {2'b00, d2_r, 1'b0};
  assign c3 = PROD_W'(d3_r) + {2'b00, d3_r, 1'b0};
  assign c5 = PROD_W'(ram_rdata) + {1'b0, ram_rdata, 2'b00};
  assign min23 = (c3 < c2) ? c3 : c2;
  assign min_val = (c5 < min23) ? c5 : min23;

  hnd_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_N)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r <= pos_nxt;
    idx_r <= idx_nxt;
    p2_r <= p2_nxt;
    p3_r <= p3_nxt;
    p5_r <= p5_nxt;
    d2_r <= d2_nxt;
    d3_r <= d3_nxt;
    last_r <= last_nxt;
    bad_r <= bad_nxt;
    out_value_r <= out_value_nxt;
    out_bad_r <= out_bad_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt = pos_r;
    idx_nxt = idx_r;
    p2_nxt = p2_r;
    p3_nxt = p3_r;
    p5_nxt = p5_r;
    d2_nxt = d2_r;
    d3_nxt = d3_r;
    last_nxt = last_r;
    bad_nxt = bad_r;
    out_value_nxt = out_value_r;
    out_bad_nxt = out_bad_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready = 1'b0;
    ram_we = 1'b0;
    ram_addr = p2_r;
    ram_wdata = last_r;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          pos_nxt = in_pos;
          if (in_pos == '0 || in_pos > MAX_POS) begin
            bad_nxt = 1'b1;
            last_nxt = '0;
            state_nxt = ST_FINISH;
          end else begin
            bad_nxt = 1'b0;
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        ram_we = 1'b1;
        ram_addr = '0;
        ram_wdata = VAL_W'(1);
        last_nxt = VAL_W'(1);
        p2_nxt = '0;
        p3_nxt = '0;
        p5_nxt = '0;
        idx_nxt = POS_W'(1);
        state_nxt = (pos_r == POS_W'(1)) ? ST_FINISH : ST_RD2;
      end
      ST_RD2: begin
        ram_addr = p2_r;
        state_nxt = ST_RD3;
      end
      ST_RD3: begin
        ram_addr = p3_r;
        d2_nxt = ram_rdata;
        state_nxt = ST_RD5;
      end
      ST_RD5: begin
        ram_addr = p5_r;
        d3_nxt = ram_rdata;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        ram_we = 1'b1;
        ram_addr = idx_r[AW-1:0];
        ram_wdata = min_val[VAL_W-1:0];
        last_nxt = min_val[VAL_W-1:0];
        if (c2 == min_val) begin
          p2_nxt = p2_r + 1'b1;
        end
        if (c3 == min_val) begin
          p3_nxt = p3_r + 1'b1;
        end
        if (c5 == min_val) begin
          p5_nxt = p5_r + 1'b1;
        end
        idx_nxt = idx_r + 1'b1;
        state_nxt = (idx_nxt < pos_r) ? ST_RD2 : ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = last_r;
          out_bad_nxt = bad_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_value_r;
  assign out_tuser = out_bad_r;

  a_ptr_behind: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CALC |-> (POS_W'(p2_r) < idx_r) && (POS_W'(p3_r) < idx_r)
                           && (POS_W'(p5_r) < idx_r))
    else $error("table pointer reached the entry being written");

  a_increasing: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CALC |-> min_val > PROD_W'(last_r))
    else $error("new sequence entry is not above the previous one");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("bad request returned a nonzero value");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in progress");

endmodule

// ===== sim/hamming_number_dp_core_tb.sv =====
module hamming_number_dp_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hnd_pkg::*;

  localparam int unsigned MAX_POS = 1024;
  localparam int unsigned LONG_HOLD = 500;
  localparam int unsigned RANDOM_REQUESTS = 170;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
    logic             bad_request;
  } hamming_answer_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [15:0]        in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [VAL_W-1:0]   out_tdata;
  logic               out_tuser;

  logic [POS_W-1:0]   pending_positions[$];
  hamming_answer_t    expected_answers[$];
  int unsigned        send_gap = 0;
  int unsigned        recv_wait = 0;
  int unsigned        sent_count = 0;
  int unsigned        recv_count = 0;
  int unsigned        error_count = 0;
  longint unsigned    cycle_count = 0;
  longint unsigned    cycle_budget = 64'd10_000_000;

  hamming_number_dp_core #(
    .MAX_N(MAX_POS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // The sequence is rebuilt for every request, just as the block does it.
  function automatic hamming_answer_t hamming_answer(input logic [POS_W-1:0] position);
    logic [VAL_W-1:0]  seq [MAX_POS];
    int unsigned       at_two;
    int unsigned       at_three;
    int unsigned       at_five;
    logic [PROD_W-1:0] by_two;
    logic [PROD_W-1:0] by_three;
    logic [PROD_W-1:0] by_five;
    logic [PROD_W-1:0] smallest;
    hamming_answer_t   answer;
    answer.position = position;
    answer.value = '0;
    answer.bad_request = 1'b1;
    if (position == 0 || position > MAX_POS) begin
      return answer;
    end
    seq[0] = 1;
    at_two = 0;
    at_three = 0;
    at_five = 0;
    for (int i = 1; i < position; i++) begin
      by_two = {3'b000, seq[at_two]} * 35'd2;
      by_three = {3'b000, seq[at_three]} * 35'd3;
      by_five = {3'b000, seq[at_five]} * 35'd5;
      smallest = by_two;
      if (by_three < smallest) smallest = by_three;
      if (by_five < smallest) smallest = by_five;
      seq[i] = smallest[VAL_W-1:0];
      if (by_two == smallest) at_two++;
      if (by_three == smallest) at_three++;
      if (by_five == smallest) at_five++;
    end
    answer.value = seq[position - 1];
    answer.bad_request = 1'b0;
    return answer;
  endfunction

  task automatic queue_position(input int unsigned position);
    pending_positions.push_back(position[POS_W-1:0]);
    if (position != 0 && position <= MAX_POS) begin
      cycle_budget += 4 * position + 20;
    end else begin
      cycle_budget += 20;
    end
  endtask

  always @(posedge clk) begin : sender
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      send_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_answers.push_back(hamming_answer(in_tdata[POS_W-1:0]));
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          in_tvalid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_positions.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= {5'b00000, pending_positions.pop_front()};
          send_gap <= (sent_count % 40 < 12) ? 0 : $urandom_range(0, 6);
          sent_count <= sent_count + 1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    int unsigned     wait_next;
    hamming_answer_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_wait <= 0;
    end else begin
      wait_next = recv_wait;
      if (out_tvalid && out_tready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: result with no request pending: value %h bad_request %b",
                   $time, out_tdata, out_tuser);
          error_count++;
        end else begin
          want = expected_answers.pop_front();
          if (out_tdata !== want.value) begin
            $display("%0t: position %0d value expected %h actual %h",
                     $time, want.position, want.value, out_tdata);
            error_count++;
          end
          if (out_tuser !== want.bad_request) begin
            $display("%0t: position %0d bad_request expected %b actual %b",
                     $time, want.position, want.bad_request, out_tuser);
            error_count++;
          end
        end
        // A long hold-off lets the block fill its output register and stall its input.
        if (recv_count == 30 || recv_count == 100) begin
          wait_next = LONG_HOLD;
        end else begin
          wait_next = (recv_count % 40 < 12) ? 0 : $urandom_range(0, 6);
        end
        recv_count <= recv_count + 1;
      end
      if (wait_next != 0) begin
        out_tready <= 1'b0;
        recv_wait <= wait_next - 1;
      end else begin
        out_tready <= 1'b1;
        recv_wait <= 0;
      end
    end
  end

  initial begin : watchdog
    @(posedge clk);
    while (cycle_count <= cycle_budget) begin
      @(posedge clk);
      cycle_count = cycle_count + 1;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned directed_list[$];
    int unsigned pick;
    directed_list = {1, 2, 3, 4, 5, 6, 7, 8, 0, 1024, 1025, 2047, 1023, 12, 1536,
                     15, 16, 1690, 64, 0, 512, 255, 1};
    cycle_budget = 1000 + 2 * LONG_HOLD;
    foreach (directed_list[i]) begin
      queue_position(directed_list[i]);
    end
    repeat (RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        queue_position($urandom_range(1, 40));
      end else if (pick < 80) begin
        queue_position($urandom_range(41, 300));
      end else if (pick < 92) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_position(0);
        end else begin
          queue_position($urandom_range(MAX_POS + 1, 2047));
        end
      end else if (pick < 98) begin
        queue_position($urandom_range(0, 2047));
      end else begin
        queue_position($urandom_range(MAX_POS - 8, MAX_POS));
      end
    end
    cycle_budget = 4 * cycle_budget;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (pending_positions.size() != 0 || in_tvalid || expected_answers.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
